// ===== hw/rtl/b2u_pkg.sv =====
package b2u_pkg;

  // bit buffer geometry
  localparam int BUF_W      = 27;
  localparam int CNT_W      = 5;
  localparam int FULL_BITS  = 20;  // a full group needs this many pending bits
  localparam int CLAMP_BITS = 19;  // pending bits kept when a new byte arrives
  localparam int SHORT_W    = 7;   // widest field taken in one extraction
  localparam int FIELD_6    = 6;
  localparam int ONE_BIT_AT = 14;  // pending bits that add the extra class bit

  // output bytes per input beat
  localparam int K_W   = 4;
  localparam int K_MAX = 6;        // no new group once more than this many bytes are out

  // value classes
  localparam logic [6:0] VAL_SPACE   = 7'h20;
  localparam logic [6:0] VAL_TWO_LIM = 7'd30;
  localparam logic [6:0] VAL_C31     = 7'd31;
  localparam logic [6:0] VAL_QUOTE   = 7'd34;
  localparam logic [6:0] VAL_BSLASH  = 7'd92;

  // byte tags
  localparam logic [7:0] LEAD_2B     = 8'b1100_0000;
  localparam logic [7:0] LEAD_C30    = 8'b1110_0010;
  localparam logic [7:0] LEAD_C31    = 8'b1110_0110;
  localparam logic [7:0] LEAD_QUOTE  = 8'b1110_1010;
  localparam logic [7:0] LEAD_BSLASH = 8'b1110_1110;
  localparam logic [7:0] CONT_TAG    = 8'b1000_0000;
  localparam logic [5:0] CONT_MASK   = 6'b11_1111;

  // group queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // one encoded group: 1 to 3 bytes, byte 0 goes out first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            last;    // final group of the input beat
  } group_t;

endpackage

// ===== hw/rtl/b2u_front.sv =====
module b2u_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_final_byte,
  output logic            push,
  output b2u_pkg::group_t push_group,
  input  logic            q_full
);
  import b2u_pkg::*;

  typedef enum logic {F_IDLE, F_GROUP} fstate_t;

  fstate_t              state_r, state_nxt;
  logic [BUF_W-1:0]     bits_r, bits_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 final_r, final_nxt;
  logic [K_W-1:0]       k_r, k_nxt;

  logic [CNT_W-1:0]     rem1, pos2, pos3, pos4, cnt_after, cnt_clamp;
  logic [2:0]           n7, m6, wn, p6;
  logic [6:0]           v, vp2, f2, f3, fw, w, w3;
  logic                 o1, is_one, is_two, cont, more;
  logic [7:0]           lead;
  logic [K_W-1:0]       k_after;
  group_t               grp;

  function automatic logic [6:0] take_field(logic [BUF_W-1:0] bits_i,
                                            logic [CNT_W-1:0] pos,
                                            logic [2:0] n);
    logic [BUF_W-1:0] sh;
    sh = bits_i >> pos;
    return sh[6:0] & ~(7'h7F << n);
  endfunction

  // group extraction from the current pending count
  always_comb begin
    n7   = (cnt_r < CNT_W'(SHORT_W)) ? cnt_r[2:0] : 3'(SHORT_W);
    rem1 = cnt_r - CNT_W'(n7);
    v    = take_field(bits_r, rem1, n7);
    m6   = (rem1 < CNT_W'(FIELD_6)) ? rem1[2:0] : 3'(FIELD_6);
    o1   = (cnt_r >= CNT_W'(ONE_BIT_AT));

    // two-byte path
    vp2  = v + 7'd2;
    pos2 = rem1 - CNT_W'(m6);
    f2   = take_field(bits_r, pos2, m6);

    // three-byte path
    wn   = (m6 != 3'd0) ? (m6 + 3'(o1)) : 3'd0;
    pos3 = rem1 - CNT_W'(wn);
    fw   = take_field(bits_r, pos3, wn);
    w    = (m6 != 3'd0) ? fw : v;
    p6   = (pos3 < CNT_W'(FIELD_6)) ? pos3[2:0] : 3'(FIELD_6);
    pos4 = pos3 - CNT_W'(p6);
    f3   = take_field(bits_r, pos4, p6);
    w3   = (p6 != 3'd0) ? f3 : w;

    is_one = (v >= VAL_SPACE) && (v != VAL_QUOTE) && (v != VAL_BSLASH);
    is_two = (v < VAL_TWO_LIM);

    if (v == VAL_TWO_LIM) begin
      lead = LEAD_C30;
    end else if (v == VAL_C31) begin
      lead = LEAD_C31;
    end else if (v == VAL_QUOTE) begin
      lead = LEAD_QUOTE;
    end else begin
      lead = LEAD_BSLASH;
    end

    grp.bytes = '0;
    grp.last  = 1'b0;
    if (is_one) begin
      grp.bytes[0] = {1'b0, v};
      grp.nbytes   = 2'd1;
      cnt_after    = rem1;
    end else if (is_two) begin
      grp.bytes[0] = LEAD_2B | {1'b0, vp2};
      grp.bytes[1] = CONT_TAG | {1'b0, (m6 != 3'd0) ? f2 : vp2};
      grp.nbytes   = 2'd2;
      cnt_after    = pos2;
    end else begin
      grp.bytes[0] = lead | {7'b0, w[6]};
      grp.bytes[1] = CONT_TAG | {2'b0, w[5:0] & CONT_MASK};
      grp.bytes[2] = CONT_TAG | {2'b0, w3[5:0] & CONT_MASK};
      grp.nbytes   = 2'd3;
      cnt_after    = pos4;
    end

    k_after = k_r + K_W'(grp.nbytes);
    cont    = ((cnt_r >= CNT_W'(FULL_BITS)) || (final_r && (cnt_r != '0)))
              && (k_r <= K_W'(K_MAX));
    more    = ((cnt_after >= CNT_W'(FULL_BITS)) || (final_r && (cnt_after != '0)))
              && (k_after <= K_W'(K_MAX));
    grp.last = !more;
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push       = (state_r == F_GROUP) && cont && !q_full;
  assign push_group = grp;
  assign cnt_clamp  = (cnt_r > CNT_W'(CLAMP_BITS)) ? CNT_W'(CLAMP_BITS) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    final_nxt = final_r;
    k_nxt     = k_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          bits_nxt  = {bits_r[BUF_W-9:0], in_data_byte};
          cnt_nxt   = cnt_clamp + CNT_W'(8);
          final_nxt = in_final_byte;
          k_nxt     = '0;
          state_nxt = F_GROUP;
        end
      end
      F_GROUP: begin
        if (!cont) begin
          state_nxt = F_IDLE;
        end else if (!q_full) begin
          cnt_nxt = cnt_after;
          k_nxt   = k_after;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      bits_r  <= '0;
      cnt_r   <= '0;
      final_r <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      bits_r  <= bits_nxt;
      cnt_r   <= cnt_nxt;
      final_r <= final_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== hw/rtl/b2u_fifo.sv =====
module b2u_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b2u_pkg::group_t push_group,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output b2u_pkg::group_t head
);
  import b2u_pkg::*;

  group_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     fill_r;

  assign full       = (fill_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/b2u_back.sv =====
module b2u_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  b2u_pkg::group_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_text_byte,
  output logic            out_run_last
);
  import b2u_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [7:0] sel_byte;
  logic       at_end, load;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      default: sel_byte = head.bytes[2];
    endcase
  end

  assign at_end = (idx_r == (head.nbytes - 2'd1));
  assign load   = head_valid && (!out_valid_r || out_ready);
  assign pop    = load && at_end;

  assign out_valid     = out_valid_r;
  assign out_text_byte = byte_r;
  assign out_run_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      last_r <= head.last && at_end;
    end
  end

endmodule

// ===== hw/rtl/binary_to_utf8_text_encoder.sv =====
// channel  | ports                                   | dir | beat
// ---------+-----------------------------------------+-----+-----------------------------
// input    | in_valid in_ready in_data_byte          | in  | one raw byte, MSB first
//          | in_final_byte                           |     | 1 = end of stream, flush
// result   | out_valid out_ready out_text_byte       | out | one UTF-8 byte
//          | out_run_last                            |     | 1 = last byte of this input
//
// Sequence: an input beat is accepted while the front is idle, then the front forms
//   its groups (1-3 text bytes each) one after another while the queue is not full:
//   0-2 groups for a normal beat, up to 4 on a flush, and then returns to idle once it
//   finds the beat done. This front loop sets the rate, as the back sends one text byte
//   per cycle and keeps up through the queue unless out_ready is held low.
// Reset: synchronous, active low; clears the bit buffer, count, queue and output.
// Stalls: in_ready is high only while the front is idle; the 4-entry group queue
//   lets the front keep forming groups while the output is held, and group forming
//   stalls only when the queue is full.
module binary_to_utf8_text_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_text_byte,
  output logic       out_run_last
);
  import b2u_pkg::*;

  // front -> queue
  logic   push, q_full;
  group_t push_group;

  // queue -> back
  logic   head_valid, pop;
  group_t head;

  // bit buffer, value classification, per-beat byte budget
  b2u_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .push         (push),
    .push_group   (push_group),
    .q_full       (q_full)
  );

  // decouples group forming from byte output
  b2u_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_group(push_group),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  // serializes each group into text bytes behind an output register
  b2u_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_text_byte(out_text_byte),
    .out_run_last (out_run_last)
  );

endmodule

// ===== hw/rtl/b2u_checker.sv =====
module b2u_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_text_byte,
  input logic       out_run_last
);

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // front takes one beat, then works it off before the next
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_text_byte) && $stable(out_run_last))
    else $error("result payload changed while stalled");

endmodule

bind binary_to_utf8_text_encoder b2u_checker u_b2u_checker (.*);

// ===== dv/utf8_text_checker.sv =====
module utf8_text_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_text_byte,
  input  logic       out_run_last,
  output int         fail_count,
  output int         bytes_due
);
  import b2u_pkg::*;

  localparam int MAX_TEXT = 9;  // most text bytes one input beat can cause

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_beat_t;

  text_beat_t  text_due[$];
  logic [26:0] bit_pool;
  logic [4:0]  bit_cnt;
  logic [7:0]  step_text [MAX_TEXT];
  int          step_len;
  int          mismatches = 0;

  assign fail_count = mismatches;

  // take n bits off the old end of the pool, right-aligned
  function automatic logic [7:0] pull_bits(input int n);
    logic [7:0] got;
    got = '0;
    if (n > 0 && n <= int'(bit_cnt) && n <= 8) begin
      got = 8'((bit_pool >> (bit_cnt - n)) & ((27'd1 << n) - 27'd1));
      bit_cnt = bit_cnt - 5'(n);
      bit_pool = bit_pool & ((27'd1 << bit_cnt) - 27'd1);
    end
    return got;
  endfunction

  function automatic void keep_text(input logic [7:0] b);
    if (step_len < MAX_TEXT) begin
      step_text[step_len] = b;
      step_len++;
    end
  endfunction

  function automatic void encode_beat(input logic [7:0] din, input logic flush);
    int         width;
    int         w7;
    int         w6;
    int         w1;
    int         wt;
    logic [7:0] val;
    logic [7:0] lead;
    step_len = 0;
    if (bit_cnt > 5'(CLAMP_BITS)) bit_cnt = 5'(CLAMP_BITS);
    bit_pool = {bit_pool[18:0], din};
    bit_cnt = bit_cnt + 5'd8;
    while (int'(bit_cnt) >= FULL_BITS || (flush && bit_cnt != 0)) begin
      if (step_len > K_MAX) break;
      // field widths shrink to what is left on a flush
      width = bit_cnt;
      w7 = (width < 7) ? width : 7;
      w6 = (width <= 7) ? 0 : ((width - 7 < 6) ? width - 7 : 6);
      w1 = (width > 13) ? 1 : 0;
      wt = (width <= 14) ? 0 : ((width - 14 < 6) ? width - 14 : 6);
      val = pull_bits(w7);
      if (val >= VAL_SPACE && val != VAL_QUOTE && val != VAL_BSLASH) begin
        keep_text(val);
      end else if (val < VAL_TWO_LIM) begin
        val = val + 8'd2;
        keep_text(LEAD_2B | val);
        if (w6 > 0) val = pull_bits(w6);
        keep_text(CONT_TAG | val);
      end else begin
        case (val[6:0])
          VAL_TWO_LIM: lead = LEAD_C30;
          VAL_C31:     lead = LEAD_C31;
          VAL_QUOTE:   lead = LEAD_QUOTE;
          default:     lead = LEAD_BSLASH;
        endcase
        // a missing field keeps the class value
        if (w6 > 0) val = pull_bits(w6 + w1);
        keep_text(lead | {7'd0, val[6]});
        keep_text(CONT_TAG | {2'b00, val[5:0]});
        if (wt > 0) val = pull_bits(wt);
        keep_text(CONT_TAG | {2'b00, val[5:0]});
      end
    end
    for (int i = 0; i < step_len; i++)
      text_due.push_back(text_beat_t'{step_text[i], i == step_len - 1});
  endfunction

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst_n) begin
      text_due.delete();
      bit_pool = '0;
      bit_cnt = '0;
    end else begin
      if (in_valid && in_ready) encode_beat(in_data_byte, in_final_byte);
      if (out_valid && out_ready) begin
        if (text_due.size() == 0) begin
          $display("%0t: text_byte expected none, got %02h run_last %0b",
                   $time, out_text_byte, out_run_last);
          mismatches++;
        end else begin
          want = text_due.pop_front();
          if (out_text_byte !== want.text) begin
            $display("%0t: text_byte expected %02h, got %02h",
                     $time, want.text, out_text_byte);
            mismatches++;
          end
          if (out_run_last !== want.last) begin
            $display("%0t: run_last expected %0b, got %0b",
                     $time, want.last, out_run_last);
            mismatches++;
          end
        end
      end
    end
    bytes_due <= text_due.size();
  end

endmodule

// ===== dv/binary_to_utf8_text_encoder_tb.sv =====
module binary_to_utf8_text_encoder_tb;
  import b2u_pkg::*;

  localparam int STALL_LIMIT     = 2000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES     = 20;    // quiet time after the last text byte
  localparam int BEATS_PER_PHASE = 40;

  // the four values that open a three-byte group
  localparam logic [6:0] CLASS_VALS [4] = '{VAL_TWO_LIM, VAL_C31, VAL_QUOTE, VAL_BSLASH};

  typedef enum {GRP_ASCII, GRP_PAIR, GRP_TRIPLE, GRP_NOISE} group_kind_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_final_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_text_byte;
  logic       out_run_last;

  int fail_count;
  int bytes_due;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles = 0;
  int beats_sent = 0;
  bit raw_bits[$];   // bit stream not yet packed into input beats, oldest first

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  binary_to_utf8_text_encoder dut (.*);

  utf8_text_checker checker_i (.*);

  // receiver: random back-pressure at the current phase's rate
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog: a healthy run never goes this long without a beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one input beat; the sender may idle first, valid is only lowered in a gap
  task automatic send_beat(input logic [7:0] b, input logic last_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= last_in;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  function automatic logic [7:0] take_byte();
    logic [7:0] b;
    for (int i = 0; i < 8; i++) b = {b[6:0], raw_bits.pop_front()};
    return b;
  endfunction

  // append a field MSB first; keep at least one bit back so the stream's
  // last byte can still be flagged final
  task automatic put_bits(input int val, input int w);
    for (int i = w - 1; i >= 0; i--) raw_bits.push_back(val[i]);
    while (raw_bits.size() >= 9) send_beat(take_byte(), 1'b0);
  endtask

  // pad the leftover bits with noise and send them as the final byte
  task automatic end_stream();
    while (raw_bits.size() < 8) raw_bits.push_back(1'($urandom));
    send_beat(take_byte(), 1'b1);
  endtask

  // one well-formed group (7, 13 or 20 bits) or a byte of noise
  task automatic put_group(input group_kind_t kind);
    int v;
    case (kind)
      GRP_ASCII: begin
        do v = $urandom_range(32, 127); while (v == VAL_QUOTE || v == VAL_BSLASH);
        put_bits(v, 7);
      end
      GRP_PAIR: begin
        put_bits($urandom_range(0, 29), 7);
        put_bits($urandom_range(0, 63), 6);
      end
      GRP_TRIPLE: begin
        put_bits(CLASS_VALS[$urandom_range(3)], 7);
        put_bits($urandom_range(0, 127), 7);
        put_bits($urandom_range(0, 63), 6);
      end
      default: put_bits($urandom_range(0, 255), 8);
    endcase
  endtask

  // streams of random groups, each closed by a flush; mostly well formed so
  // the three-byte classes and the tail shapes come up often
  task automatic run_random(input int n);
    int          stop_at;
    int          groups;
    int          roll;
    group_kind_t kind;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      groups = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (groups) begin
        roll = $urandom_range(99);
        if (roll < 30)      kind = GRP_ASCII;
        else if (roll < 55) kind = GRP_PAIR;
        else if (roll < 88) kind = GRP_TRIPLE;
        else                kind = GRP_NOISE;
        put_group(kind);
      end
      end_stream();
    end
  endtask

  // hold the input low until every predicted text byte has come out
  task automatic drain_text();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_final_byte = 1'b0;
    out_ready     = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 69;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero then all-one byte; the flush ends on a pair with no payload
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);

    // every three-byte class, pair upper bound, top of the one-byte range
    put_bits(VAL_TWO_LIM, 7); put_bits(127, 7); put_bits(63, 6);
    put_bits(VAL_C31, 7);     put_bits(0, 7);   put_bits(0, 6);
    put_bits(VAL_QUOTE, 7);   put_bits(85, 7);  put_bits(42, 6);
    put_bits(VAL_BSLASH, 7);  put_bits(42, 7);  put_bits(21, 6);
    put_bits(29, 7);          put_bits(0, 6);
    put_bits(127, 7);
    end_stream();

    // one-byte group, then a 1-bit tail: pair repeats its lead value
    put_bits(65, 7);
    end_stream();

    // two pairs leave a 6-bit tail holding the quote code
    put_bits(3, 7);  put_bits(40, 6);
    put_bits(17, 7); put_bits(1, 6);
    put_bits(VAL_QUOTE, 6);
    end_stream();

    // triple and pair leave a 7-bit backslash with both fields missing
    put_bits(VAL_QUOTE, 7); put_bits(0, 7); put_bits(0, 6);
    put_bits(15, 7);        put_bits(5, 6);
    put_bits(VAL_BSLASH, 7);
    end_stream();

    run_random(BEATS_PER_PHASE);
    drain_text();

    // sender slow, receiver fast
    send_idle_pct = 69;
    recv_idle_pct <= 7;
    run_random(BEATS_PER_PHASE);
    drain_text();

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(BEATS_PER_PHASE);

    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
